[hw/rtl/vertex_triple_index_dedup_assert.svh]
// Assertion macros for the vertex triple index dedup block.
// Used by the top level; no other dependencies.
`ifndef VERTEX_TRIPLE_INDEX_DEDUP_ASSERT_SVH
`define VERTEX_TRIPLE_INDEX_DEDUP_ASSERT_SVH

// same-cycle implication
`define VTID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define VTID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/vtid_pkg.sv]
// Shared types and codes for the vertex triple index dedup block.
// No dependencies.
package vtid_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        start_mesh;
    logic [15:0] vertex_pos;
    logic [15:0] tex_pos;
    logic [15:0] normal_pos;
    logic        has_tex;
    logic        has_normal;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] unique_index;
    logic        is_new;
    logic [1:0]  status;
  } out_beat_t;

  // classified corner, all numbers zero-based
  typedef struct packed {
    logic        start;
    logic        range_err;
    logic [15:0] v;
    logic [15:0] t;
    logic [15:0] n;
  } work_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic init_busy;
    logic pop;
  } bk_stat_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_LOOK,
    B_FILL,
    B_RD,
    B_CMP,
    B_DECIDE
  } back_state_t;

endpackage

[hw/rtl/vertex_triple_index_dedup.sv]
// Top level of the vertex triple index dedup block.
// Depends on vtid_pkg, vtid_front, vtid_queue, vtid_back and the assert macros.
//
// A corner is taken when start is high and busy is low; its result appears on
// out_beat for one cycle with out_strobe and cannot be held off. A two-entry
// queue lets two corners wait while the back end works. The back end handles
// one corner at a time: it reads the fill count of the bucket, reads and
// compares the stored entries one by one, and on a miss appends a new entry;
// an out-of-range corner is answered without a lookup.
// A corner with start_mesh set first sweeps the fill-count memory. After reset
// the same sweep runs and busy stays high until it ends.
`include "vertex_triple_index_dedup_assert.svh"

module vertex_triple_index_dedup #(
  parameter int MAX_POSITIONS = 4096,
  parameter int BUCKET_WAYS   = 4,
  parameter int INDEX_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vtid_pkg::in_beat_t  in_beat,
  output logic                out_strobe,
  output vtid_pkg::out_beat_t out_beat
);

  vtid_pkg::q_stat_t  q_stat;
  vtid_pkg::bk_stat_t bk_stat;
  vtid_pkg::work_t    work;
  vtid_pkg::work_t    head;
  logic               push;

  vtid_front #(.MAX_POSITIONS(MAX_POSITIONS)) u_front (
    .start   (start),
    .busy    (busy),
    .in_beat (in_beat),
    .q_stat  (q_stat),
    .bk_stat (bk_stat),
    .push    (push),
    .work    (work)
  );

  vtid_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .work    (work),
    .bk_stat (bk_stat),
    .q_stat  (q_stat),
    .head    (head)
  );

  vtid_back #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .BUCKET_WAYS   (BUCKET_WAYS),
    .INDEX_BITS    (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .bk_stat    (bk_stat),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

  `VTID_ASSERT_NEXT(a_push_lands, clk, rst_n, push, !q_stat.empty)
  `VTID_ASSERT_NOW(a_no_out_in_init, clk, rst_n, bk_stat.init_busy, !out_strobe)
  `VTID_ASSERT_NOW(a_new_is_ok, clk, rst_n, out_strobe && out_beat.is_new,
                   out_beat.status == vtid_pkg::ST_OK)
  `VTID_ASSERT_NOW(a_err_zero, clk, rst_n,
                   out_strobe && out_beat.status != vtid_pkg::ST_OK,
                   !out_beat.is_new && out_beat.unique_index == 16'd0)

endmodule

[hw/rtl/vtid_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vtid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/vtid_front.sv]
// Front end: input handshake and corner classification.
// Depends on vtid_pkg.
module vtid_front #(
  parameter int MAX_POSITIONS = 4096
) (
  input  logic               start,
  output logic               busy,
  input  vtid_pkg::in_beat_t in_beat,
  input  vtid_pkg::q_stat_t  q_stat,
  input  vtid_pkg::bk_stat_t bk_stat,
  output logic               push,
  output vtid_pkg::work_t    work
);

  logic [15:0] vm1;
  logic [15:0] t_src;
  logic [15:0] n_src;

  assign busy = q_stat.full | bk_stat.init_busy;
  assign push = start & ~busy;

  always_comb begin
    vm1   = in_beat.vertex_pos - 16'd1;
    t_src = in_beat.has_tex ? in_beat.tex_pos : in_beat.vertex_pos;
    n_src = in_beat.has_normal ? in_beat.normal_pos : in_beat.vertex_pos;
    work.start     = in_beat.start_mesh;
    work.range_err = (in_beat.vertex_pos == 16'd0) ||
                     ({1'b0, vm1} >= 17'(MAX_POSITIONS));
    work.v         = vm1;
    work.t         = t_src - 16'd1;
    work.n         = n_src - 16'd1;
  end

endmodule

[hw/rtl/vtid_queue.sv]
// Two-entry queue of classified corners between front and back.
// Depends on vtid_pkg.
module vtid_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vtid_pkg::work_t    work,
  input  vtid_pkg::bk_stat_t bk_stat,
  output vtid_pkg::q_stat_t  q_stat,
  output vtid_pkg::work_t    head
);

  vtid_pkg::work_t ents_r [2];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = bk_stat.pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !bk_stat.pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && bk_stat.pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ents_r[wp_r] <= work;
    end
  end

  assign head   = ents_r[rp_r];
  assign q_stat = '{empty: (cnt_r == 2'd0), full: (cnt_r == 2'd2)};

endmodule

[hw/rtl/vtid_back.sv]
// Back end: bucket clear sweep, bucket search, append and result register.
// Depends on vtid_pkg and vtid_ram.
module vtid_back #(
  parameter int MAX_POSITIONS = 4096,
  parameter int BUCKET_WAYS   = 4,
  parameter int INDEX_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vtid_pkg::q_stat_t   q_stat,
  input  vtid_pkg::work_t     head,
  output vtid_pkg::bk_stat_t  bk_stat,
  output logic                out_strobe,
  output vtid_pkg::out_beat_t out_beat
);

  localparam int PW  = $clog2(MAX_POSITIONS);
  localparam int WW  = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int FW  = $clog2(BUCKET_WAYS + 1);
  localparam int NUW = INDEX_BITS + 1;
  localparam int ENT_DEPTH = MAX_POSITIONS * (2 ** WW);
  localparam logic [PW-1:0] LAST_POS = PW'(MAX_POSITIONS - 1);

  vtid_pkg::back_state_t state_r, state_nxt;
  vtid_pkg::work_t       item_r, item_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [FW-1:0]         k_r, k_nxt;
  logic [PW-1:0]         clr_r, clr_nxt;
  logic [NUW-1:0]        nu_r, nu_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  vtid_pkg::out_beat_t   out_beat_r, out_beat_nxt;

  logic                  fill_we, fill_re;
  logic [PW-1:0]         fill_waddr;
  logic [FW-1:0]         fill_wdata, fill_rdata;
  logic                  ent_we, ent_re;
  logic [PW+WW-1:0]      ent_addr;
  logic [47:0]           ent_wdata, ent_rdata;
  logic [PW-1:0]         v;
  logic [15:0]           nu16;
  logic                  pop;

  assign v    = item_r.v[PW-1:0];
  assign nu16 = 16'(nu_r[INDEX_BITS-1:0]);

  vtid_ram #(.WIDTH(FW), .DEPTH(MAX_POSITIONS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (v),
    .rdata (fill_rdata)
  );

  vtid_ram #(.WIDTH(48), .DEPTH(ENT_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_addr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_addr),
    .rdata (ent_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    fill_nxt       = fill_r;
    k_nxt          = k_r;
    clr_nxt        = clr_r;
    nu_nxt         = nu_r;
    out_strobe_nxt = 1'b0;
    out_beat_nxt   = out_beat_r;
    fill_we        = 1'b0;
    fill_re        = 1'b0;
    fill_waddr     = v;
    fill_wdata     = fill_r + FW'(1);
    ent_we         = 1'b0;
    ent_re         = 1'b0;
    // in DECIDE k equals fill, so this is also the append slot
    ent_addr       = {v, k_r[WW-1:0]};
    ent_wdata      = {item_r.n, item_r.t, nu16};
    pop            = 1'b0;
    case (state_r)
      vtid_pkg::B_INIT, vtid_pkg::B_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r;
        fill_wdata = '0;
        clr_nxt    = clr_r + PW'(1);
        if (clr_r == LAST_POS) begin
          clr_nxt = '0;
          if (state_r == vtid_pkg::B_INIT) begin
            state_nxt = vtid_pkg::B_IDLE;
          end else if (item_r.range_err) begin
            out_strobe_nxt = 1'b1;
            out_beat_nxt   = '{unique_index: 16'd0, is_new: 1'b0, status: vtid_pkg::ST_RANGE};
            state_nxt      = vtid_pkg::B_IDLE;
          end else begin
            state_nxt = vtid_pkg::B_LOOK;
          end
        end
      end
      vtid_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          item_nxt = head;
          if (head.start) begin
            nu_nxt    = '0;
            state_nxt = vtid_pkg::B_CLEAR;
          end else if (head.range_err) begin
            out_strobe_nxt = 1'b1;
            out_beat_nxt   = '{unique_index: 16'd0, is_new: 1'b0, status: vtid_pkg::ST_RANGE};
          end else begin
            state_nxt = vtid_pkg::B_LOOK;
          end
        end
      end
      vtid_pkg::B_LOOK: begin
        fill_re   = 1'b1;
        state_nxt = vtid_pkg::B_FILL;
      end
      vtid_pkg::B_FILL: begin
        fill_nxt  = fill_rdata;
        k_nxt     = '0;
        state_nxt = vtid_pkg::B_RD;
      end
      vtid_pkg::B_RD: begin
        if (k_r == fill_r) begin
          state_nxt = vtid_pkg::B_DECIDE;
        end else begin
          ent_re    = 1'b1;
          state_nxt = vtid_pkg::B_CMP;
        end
      end
      vtid_pkg::B_CMP: begin
        if (ent_rdata[47:32] == item_r.n && ent_rdata[31:16] == item_r.t) begin
          out_strobe_nxt = 1'b1;
          out_beat_nxt   = '{unique_index: ent_rdata[15:0], is_new: 1'b0,
                             status: vtid_pkg::ST_OK};
          state_nxt      = vtid_pkg::B_IDLE;
        end else begin
          k_nxt     = k_r + FW'(1);
          state_nxt = vtid_pkg::B_RD;
        end
      end
      vtid_pkg::B_DECIDE: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = vtid_pkg::B_IDLE;
        if (fill_r == FW'(BUCKET_WAYS) || nu_r[INDEX_BITS]) begin
          out_beat_nxt = '{unique_index: 16'd0, is_new: 1'b0, status: vtid_pkg::ST_FULL};
        end else begin
          ent_we       = 1'b1;
          fill_we      = 1'b1;
          nu_nxt       = nu_r + NUW'(1);
          out_beat_nxt = '{unique_index: nu16, is_new: 1'b1, status: vtid_pkg::ST_OK};
        end
      end
      default: begin
        state_nxt = vtid_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vtid_pkg::B_INIT;
      clr_r        <= '0;
      nu_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      nu_r         <= nu_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    fill_r     <= fill_nxt;
    k_r        <= k_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign bk_stat    = '{init_busy: (state_r == vtid_pkg::B_INIT), pop: pop};
  assign out_strobe = out_strobe_r;
  assign out_beat   = out_beat_r;

endmodule
